// ----- hw/rtl/krc_pkg.sv -----
// Shared types, constants and helpers for the key-repeat cursor core.
// Used by every module under hw/rtl; depends on nothing.
package krc_pkg;

    localparam int COORD_BITS  = 8;
    localparam int TICK_BITS   = 16;
    localparam int TICK_CNT_W  = TICK_BITS + 1;
    localparam int DIM_W       = 9;
    localparam int MARGIN_W    = 7;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    // power of two, at least two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MOD_CNT_W   = $clog2(TICK_CNT_W);

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = CFG_IDX_W'(7);

    typedef struct packed {
        logic               kind;
        logic [3:0]         held_keys;
        logic [3:0]         released_keys;
        logic               other_released;
        logic [15:0]        elapsed_ticks;
        logic signed [15:0] place_x;
        logic signed [15:0] place_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  cursor_col;
        logic [7:0]  cursor_row;
        logic [7:0]  corner_col;
        logic [7:0]  corner_row;
        logic [7:0]  prev_cursor_col;
        logic [7:0]  prev_cursor_row;
        logic [7:0]  prev_corner_col;
        logic [7:0]  prev_corner_row;
        logic        stepped;
        logic [16:0] since_step;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]    map_width;
        logic [DIM_W-1:0]    map_height;
        logic [DIM_W-1:0]    view_width;
        logic [DIM_W-1:0]    view_height;
        logic [MARGIN_W-1:0] margin_x;
        logic [MARGIN_W-1:0] margin_y;
        logic [TICK_BITS-1:0] first_repeat_ticks;
        logic [TICK_BITS-1:0] repeat_ticks;
    } cfg_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic                  is_place;
        logic                  fresh;
        logic                  reload;
        logic signed [1:0]     dir_x;
        logic signed [1:0]     dir_y;
        logic [TICK_BITS-1:0]  elapsed;
        logic [COORD_BITS-1:0] place_col;
        logic [COORD_BITS-1:0] place_row;
    } cmd_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QLVL_W-1:0] level;
    } queue_stat_t;

    typedef struct packed {
        logic                  start;
        logic [TICK_CNT_W-1:0] dividend;
        logic [TICK_BITS-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic                 done;
        logic [TICK_BITS-1:0] remainder;
    } mod_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TICK,
        BK_MOD,
        BK_STEP,
        BK_FOLLOW,
        BK_OUT
    } back_state_t;

    // Map size limited to 1 .. 2^COORD_BITS.
    function automatic logic [COORD_BITS:0] eff_map(input logic [DIM_W-1:0] m);
        logic [COORD_BITS:0] top;
        top = {1'b1, {COORD_BITS{1'b0}}};
        if (m == '0) begin
            return (COORD_BITS+1)'(1);
        end
        if (m > DIM_W'(top)) begin
            return top;
        end
        return (COORD_BITS+1)'(m);
    endfunction

    // Last valid coordinate on an axis.
    function automatic logic [COORD_BITS-1:0] map_last(input logic [DIM_W-1:0] m);
        logic [COORD_BITS:0] e;
        e = eff_map(m) - (COORD_BITS+1)'(1);
        return e[COORD_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/krc_front.sv -----
// Front end: takes input words, tracks the direction keys and classifies each word.
// Depends on krc_pkg; feeds krc_queue.
module krc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  krc_pkg::cfg_t     cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  krc_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              push,
    output krc_pkg::cmd_t     push_cmd
);
    import krc_pkg::*;

    logic [3:0] key_down_reg;
    logic [3:0] key_down_next;
    logic [3:0] keys_held;
    logic       newly_pressed;
    logic       reload;
    logic [COORD_BITS-1:0] last_col;
    logic [COORD_BITS-1:0] last_row;

    function automatic logic [COORD_BITS-1:0] clamp_place(
        input logic signed [15:0]   p,
        input logic [COORD_BITS-1:0] last
    );
        if (p[15]) begin
            return '0;
        end
        if (p[14:0] > {{(15-COORD_BITS){1'b0}}, last}) begin
            return last;
        end
        return p[COORD_BITS-1:0];
    endfunction

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        keys_held     = key_down_reg | s_data.held_keys;
        newly_pressed = (s_data.held_keys & ~key_down_reg) != 4'b0000;
        reload        = (s_data.released_keys != 4'b0000) || s_data.other_released;
        // hold first, then release clears the key
        key_down_next = reload ? (keys_held & ~s_data.released_keys) : keys_held;
        last_col      = map_last(cfg.map_width);
        last_row      = map_last(cfg.map_height);

        push_cmd.is_place  = s_data.kind;
        push_cmd.fresh     = newly_pressed || reload;
        push_cmd.reload    = reload;
        push_cmd.dir_x     = {1'b0, key_down_next[3]} - {1'b0, key_down_next[2]};
        push_cmd.dir_y     = {1'b0, key_down_next[1]} - {1'b0, key_down_next[0]};
        push_cmd.elapsed   = s_data.elapsed_ticks;
        push_cmd.place_col = clamp_place(s_data.place_x, last_col);
        push_cmd.place_row = clamp_place(s_data.place_y, last_row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_down_reg <= 4'b0000;
        end else if (push && !s_data.kind) begin
            key_down_reg <= key_down_next;
        end
    end

endmodule

// ----- hw/rtl/krc_queue.sv -----
// Short queue of classified words between the front and the back.
// Depends on krc_pkg for cmd_t and the queue depth.
module krc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  krc_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output krc_pkg::cmd_t        pop_cmd,
    output krc_pkg::queue_stat_t stat
);
    import krc_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign stat.empty = level_reg == '0;
    assign stat.full  = level_reg == QLVL_W'(QUEUE_DEPTH);
    assign stat.level = level_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers wrap on their own: depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                level_reg <= level_reg + QLVL_W'(1);
            end else if (pop && !push) begin
                level_reg <= level_reg - QLVL_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/krc_mod.sv -----
// Restoring remainder unit: one dividend bit per cycle.
// Depends on krc_pkg; used by krc_back to reduce the tick count.
module krc_mod (
    input  logic              aclk,
    input  logic              aresetn,
    input  krc_pkg::mod_req_t req,
    output krc_pkg::mod_rsp_t rsp
);
    import krc_pkg::*;

    logic [TICK_CNT_W-1:0] quo_reg;
    logic [TICK_BITS-1:0]  rem_reg;
    logic [TICK_BITS-1:0]  div_reg;
    logic [MOD_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [TICK_BITS:0]    trial;
    logic [TICK_BITS:0]    diff;
    logic [TICK_BITS-1:0]  rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[TICK_CNT_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = (trial >= {1'b0, div_reg}) ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[TICK_CNT_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + MOD_CNT_W'(1);
                if (cnt_reg == MOD_CNT_W'(TICK_CNT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/krc_back.sv -----
// Back end: tick and repeat decision, cursor step, view follow, output register.
// Depends on krc_pkg and krc_mod; pops words from krc_queue.
module krc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  krc_pkg::cfg_t        cfg,
    input  krc_pkg::queue_stat_t q_stat,
    input  krc_pkg::cmd_t        pop_cmd,
    output logic                 pop,
    output logic                 busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output krc_pkg::out_item_t   m_data
);
    import krc_pkg::*;

    localparam int FW = DIM_W + 3;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic        first_pending_reg, first_pending_next;
    logic signed [1:0] step_dx_reg, step_dx_next;
    logic signed [1:0] step_dy_reg, step_dy_next;
    logic [TICK_CNT_W-1:0] tick_reg, tick_next;
    logic [COORD_BITS-1:0] cur_col_reg, cur_col_next;
    logic [COORD_BITS-1:0] cur_row_reg, cur_row_next;
    logic [COORD_BITS:0]   cor_col_reg, cor_col_next;
    logic [COORD_BITS:0]   cor_row_reg, cor_row_next;
    logic [COORD_BITS-1:0] pcur_col_reg, pcur_col_next;
    logic [COORD_BITS-1:0] pcur_row_reg, pcur_row_next;
    logic [COORD_BITS:0]   pcor_col_reg, pcor_col_next;
    logic [COORD_BITS:0]   pcor_row_reg, pcor_row_next;
    logic        stepped_reg, stepped_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;
    logic        out_load;

    logic [TICK_CNT_W-1:0] tick_sum;
    logic [TICK_BITS-1:0]  thr_first;
    logic [TICK_BITS-1:0]  thr_rep;
    logic                  hit_first;
    logic                  hit_rep;
    logic signed [1:0]     base_dx;
    logic signed [1:0]     base_dy;
    logic [COORD_BITS:0]   follow_col;
    logic [COORD_BITS:0]   follow_row;
    mod_req_t              mod_req;
    mod_rsp_t              mod_rsp;

    function automatic logic signed [1:0] sat_delta(
        input logic signed [1:0] dir,
        input logic signed [1:0] base
    );
        logic signed [2:0] d;
        d = {dir[1], dir} - {base[1], base};
        if (d > 3'sd1) begin
            return 2'sb01;
        end
        if (d < -3'sd1) begin
            return 2'sb11;
        end
        return d[1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] step_axis(
        input logic [COORD_BITS-1:0] cur,
        input logic signed [1:0]     d,
        input logic [COORD_BITS-1:0] last
    );
        logic signed [COORD_BITS+1:0] s;
        logic signed [COORD_BITS+1:0] hi;
        s  = $signed({2'b00, cur}) + $signed({{COORD_BITS{d[1]}}, d});
        hi = $signed({2'b00, last});
        if (s < 0) begin
            return '0;
        end
        if (s > hi) begin
            return last;
        end
        return s[COORD_BITS-1:0];
    endfunction

    // Keep the cursor margin tiles inside the view, then clamp to [0, map - view].
    function automatic logic [COORD_BITS:0] follow_axis(
        input logic [COORD_BITS-1:0] cur,
        input logic [COORD_BITS:0]   corner,
        input logic [DIM_W-1:0]      map,
        input logic [DIM_W-1:0]      view,
        input logic [MARGIN_W-1:0]   margin
    );
        logic signed [FW-1:0] cur_s;
        logic signed [FW-1:0] cor_s;
        logic signed [FW-1:0] mg_s;
        logic signed [FW-1:0] view_s;
        logic signed [FW-1:0] far_s;
        logic signed [FW-1:0] diff_s;
        logic signed [FW-1:0] em_s;
        logic signed [FW-1:0] bound_s;
        logic signed [FW-1:0] c;
        cur_s   = FW'(cur);
        cor_s   = FW'(corner);
        mg_s    = FW'(margin);
        view_s  = FW'(view);
        em_s    = FW'(eff_map(map));
        far_s   = view_s - FW'(1) - mg_s;
        diff_s  = cur_s - cor_s;
        bound_s = (em_s > view_s) ? (em_s - view_s) : '0;
        if (diff_s < mg_s) begin
            c = cur_s - mg_s;
        end else if (diff_s > far_s) begin
            c = cur_s - far_s;
        end else begin
            c = cor_s;
        end
        if (c < 0) begin
            return '0;
        end
        if (c > bound_s) begin
            return bound_s[COORD_BITS:0];
        end
        return c[COORD_BITS:0];
    endfunction

    krc_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    // repeat decision, view follow targets and output load
    always_comb begin
        tick_sum  = tick_reg + TICK_CNT_W'(cmd_reg.elapsed);
        thr_first = (cfg.first_repeat_ticks == '0) ? TICK_BITS'(1) : cfg.first_repeat_ticks;
        thr_rep   = (cfg.repeat_ticks == '0) ? TICK_BITS'(1) : cfg.repeat_ticks;
        hit_first = first_pending_reg && (tick_sum >= {1'b0, thr_first});
        hit_rep   = !first_pending_reg && (tick_sum >= {1'b0, thr_rep});
        base_dx   = cmd_reg.reload ? cmd_reg.dir_x : step_dx_reg;
        base_dy   = cmd_reg.reload ? cmd_reg.dir_y : step_dy_reg;
        follow_col = follow_axis(cur_col_reg, cor_col_reg, cfg.map_width,
                                 cfg.view_width, cfg.margin_x);
        follow_row = follow_axis(cur_row_reg, cor_row_reg, cfg.map_height,
                                 cfg.view_height, cfg.margin_y);
        out_load  = (state_reg == BK_OUT) && (!out_valid_reg || m_ready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = BK_TICK;
                end
            end
            BK_TICK: begin
                if (cmd_reg.is_place) begin
                    state_next = BK_FOLLOW;
                end else if (cmd_reg.fresh) begin
                    state_next = BK_STEP;
                end else if (hit_first || hit_rep) begin
                    state_next = BK_MOD;
                end else begin
                    state_next = BK_OUT;
                end
            end
            BK_MOD: begin
                if (mod_rsp.done) begin
                    state_next = BK_STEP;
                end
            end
            BK_STEP:   state_next = BK_FOLLOW;
            BK_FOLLOW: state_next = BK_OUT;
            BK_OUT: begin
                if (out_load) begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        first_pending_next = first_pending_reg;
        step_dx_next       = step_dx_reg;
        step_dy_next       = step_dy_reg;
        tick_next          = tick_reg;
        cur_col_next       = cur_col_reg;
        cur_row_next       = cur_row_reg;
        cor_col_next       = cor_col_reg;
        cor_row_next       = cor_row_reg;
        pcur_col_next      = pcur_col_reg;
        pcur_row_next      = pcur_row_reg;
        pcor_col_next      = pcor_col_reg;
        pcor_row_next      = pcor_row_reg;
        stepped_next       = stepped_reg;
        pop                = 1'b0;
        mod_req.start      = 1'b0;
        mod_req.dividend   = tick_sum;
        mod_req.divisor    = first_pending_reg ? thr_first : thr_rep;

        case (state_reg)
            BK_IDLE: begin
                pop = !q_stat.empty;
            end
            BK_TICK: begin
                if (cmd_reg.is_place) begin
                    cur_col_next = cmd_reg.place_col;
                    cur_row_next = cmd_reg.place_row;
                    stepped_next = 1'b0;
                end else if (cmd_reg.fresh) begin
                    tick_next          = '0;
                    stepped_next       = 1'b1;
                    first_pending_next = 1'b1;
                    step_dx_next       = sat_delta(cmd_reg.dir_x, base_dx);
                    step_dy_next       = sat_delta(cmd_reg.dir_y, base_dy);
                end else if (hit_first || hit_rep) begin
                    stepped_next       = 1'b1;
                    first_pending_next = 1'b0;
                    step_dx_next       = cmd_reg.dir_x;
                    step_dy_next       = cmd_reg.dir_y;
                    mod_req.start      = 1'b1;
                end else begin
                    tick_next    = tick_sum;
                    stepped_next = 1'b0;
                end
            end
            BK_MOD: begin
                if (mod_rsp.done) begin
                    tick_next = TICK_CNT_W'(mod_rsp.remainder);
                end
            end
            BK_STEP: begin
                pcur_col_next = cur_col_reg;
                pcur_row_next = cur_row_reg;
                pcor_col_next = cor_col_reg;
                pcor_row_next = cor_row_reg;
                cur_col_next  = step_axis(cur_col_reg, step_dx_reg, map_last(cfg.map_width));
                cur_row_next  = step_axis(cur_row_reg, step_dy_reg, map_last(cfg.map_height));
            end
            BK_FOLLOW: begin
                cor_col_next = follow_col;
                cor_row_next = follow_row;
                if (cmd_reg.is_place) begin
                    pcur_col_next = cur_col_reg;
                    pcur_row_next = cur_row_reg;
                    pcor_col_next = follow_col;
                    pcor_row_next = follow_row;
                end
            end
            BK_OUT: begin
            end
            default: begin
            end
        endcase

        out_next.cursor_col      = cur_col_reg;
        out_next.cursor_row      = cur_row_reg;
        out_next.corner_col      = cor_col_reg[COORD_BITS-1:0];
        out_next.corner_row      = cor_row_reg[COORD_BITS-1:0];
        out_next.prev_cursor_col = pcur_col_reg;
        out_next.prev_cursor_row = pcur_row_reg;
        out_next.prev_corner_col = pcor_col_reg[COORD_BITS-1:0];
        out_next.prev_corner_row = pcor_row_reg[COORD_BITS-1:0];
        out_next.stepped         = stepped_reg;
        out_next.since_step      = tick_reg;

        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign busy    = state_reg != BK_IDLE;

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= pop_cmd;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= BK_IDLE;
            first_pending_reg <= 1'b0;
            step_dx_reg       <= '0;
            step_dy_reg       <= '0;
            tick_reg          <= '0;
            cur_col_reg       <= '0;
            cur_row_reg       <= '0;
            cor_col_reg       <= '0;
            cor_row_reg       <= '0;
            pcur_col_reg      <= '0;
            pcur_row_reg      <= '0;
            pcor_col_reg      <= '0;
            pcor_row_reg      <= '0;
            stepped_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            first_pending_reg <= first_pending_next;
            step_dx_reg       <= step_dx_next;
            step_dy_reg       <= step_dy_next;
            tick_reg          <= tick_next;
            cur_col_reg       <= cur_col_next;
            cur_row_reg       <= cur_row_next;
            cor_col_reg       <= cor_col_next;
            cor_row_reg       <= cor_row_next;
            pcur_col_reg      <= pcur_col_next;
            pcur_row_reg      <= pcur_row_next;
            pcor_col_reg      <= pcor_col_next;
            pcor_row_reg      <= pcor_row_next;
            stepped_reg       <= stepped_next;
            out_valid_reg     <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/key_repeat_cursor_scroll_core.sv -----
// Top level of the key-repeat tile cursor with a scrolling view.
// Depends on krc_pkg, krc_front, krc_queue and krc_back (which holds krc_mod).
//
// Input words (s_valid/s_ready/s_data) are frame updates or cursor placements;
// every word gives exactly one result word on m_valid/m_ready/m_data, in order.
// The front takes a word whenever its two-entry queue has room, so it keeps
// accepting while the back is busy or a result waits at the output register.
// Per word the back steps IDLE (pop), TICK, OUT with no step; a placement adds
// FOLLOW, a fresh step STEP and FOLLOW, and a repeat step MOD, STEP and FOLLOW,
// where MOD waits for the bit-serial krc_mod to reduce the tick count. The back
// takes one word at a time, so its sequencer sets the sustained word rate.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at once;
// write only while no word is in flight. Reset (aresetn low, synchronous)
// loads the default registers and clears keys, ticks and all positions.
// While m_ready stays low the result holds, the back waits with the next result
// and further words collect in the queue until s_ready drops.
module key_repeat_cursor_scroll_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [krc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [krc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  krc_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output krc_pkg::out_item_t                   m_data
);
    import krc_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        push_cmd;
    cmd_t        pop_cmd;
    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    logic        back_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_width          <= DIM_W'(256);
            cfg_reg.map_height         <= DIM_W'(256);
            cfg_reg.view_width         <= DIM_W'(16);
            cfg_reg.view_height        <= DIM_W'(12);
            cfg_reg.margin_x           <= MARGIN_W'(2);
            cfg_reg.margin_y           <= MARGIN_W'(2);
            cfg_reg.first_repeat_ticks <= TICK_BITS'(300);
            cfg_reg.repeat_ticks       <= TICK_BITS'(80);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAP_WIDTH:    cfg_reg.map_width          <= cfg_wdata[DIM_W-1:0];
                CFG_MAP_HEIGHT:   cfg_reg.map_height         <= cfg_wdata[DIM_W-1:0];
                CFG_VIEW_WIDTH:   cfg_reg.view_width         <= cfg_wdata[DIM_W-1:0];
                CFG_VIEW_HEIGHT:  cfg_reg.view_height        <= cfg_wdata[DIM_W-1:0];
                CFG_MARGIN_X:     cfg_reg.margin_x           <= cfg_wdata[MARGIN_W-1:0];
                CFG_MARGIN_Y:     cfg_reg.margin_y           <= cfg_wdata[MARGIN_W-1:0];
                CFG_FIRST_REPEAT: cfg_reg.first_repeat_ticks <= cfg_wdata[TICK_BITS-1:0];
                CFG_REPEAT:       cfg_reg.repeat_ticks       <= cfg_wdata[TICK_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    krc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_stat.full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    krc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    krc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_stat  (q_stat),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .busy    (back_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a step leaves a reduced count: its top bit (bit TICK_BITS) is clear
    a_step_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stepped) |-> (m_data.since_step[TICK_BITS] == 1'b0))
        else $error("tick count not reduced after a step");

    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // an accepted word is either queued or already in the back
    a_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!q_stat.empty || back_busy))
        else $error("accepted word lost");

    a_pop_only_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

// ----- tb/tb_key_repeat_cursor_scroll_core.sv -----
// Self-checking testbench for key_repeat_cursor_scroll_core.
// Holds its own cursor/view tracker and scoreboard; needs krc_pkg and the core RTL.
// Directed words, then random key-hold sequences over several register settings.
module tb_key_repeat_cursor_scroll_core;
    import krc_pkg::*;

    // Tracks the cursor, view corner and key-repeat timing, and holds the
    // result words still owed by the core.
    class cursor_tracker;
        logic [DIM_W-1:0]     map_w, map_h, view_w, view_h;
        logic [MARGIN_W-1:0]  margin_x, margin_y;
        logic [TICK_BITS-1:0] first_thr, repeat_thr;
        logic [3:0]           keys_down;
        logic                 first_pending;
        logic signed [1:0]    step_dx, step_dy;
        logic [TICK_CNT_W-1:0] ticks;
        logic [7:0]           cur_col, cur_row, cor_col, cor_row;
        logic [7:0]           prev_cur_col, prev_cur_row, prev_cor_col, prev_cor_row;
        out_item_t            owed_views[$];
        int                   errors;
        int                   words_seen;

        function new();
            map_w = 256; map_h = 256; view_w = 16; view_h = 12;
            margin_x = 2; margin_y = 2; first_thr = 300; repeat_thr = 80;
            keys_down = '0; first_pending = 1'b0; step_dx = '0; step_dy = '0;
            ticks = '0;
            cur_col = '0; cur_row = '0; cor_col = '0; cor_row = '0;
            prev_cur_col = '0; prev_cur_row = '0; prev_cor_col = '0; prev_cor_row = '0;
            errors = 0;
            words_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MAP_WIDTH:    map_w = val[DIM_W-1:0];
                CFG_MAP_HEIGHT:   map_h = val[DIM_W-1:0];
                CFG_VIEW_WIDTH:   view_w = val[DIM_W-1:0];
                CFG_VIEW_HEIGHT:  view_h = val[DIM_W-1:0];
                CFG_MARGIN_X:     margin_x = val[MARGIN_W-1:0];
                CFG_MARGIN_Y:     margin_y = val[MARGIN_W-1:0];
                CFG_FIRST_REPEAT: first_thr = val;
                CFG_REPEAT:       repeat_thr = val;
                default: ;
            endcase
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // Map size seen by the cursor: 1 .. 2^COORD_BITS.
        function int span(logic [DIM_W-1:0] m);
            if (m == 0) return 1;
            if (m > 256) return 256;
            return int'(m);
        endfunction

        function int threshold(logic [TICK_BITS-1:0] t);
            return (t == 0) ? 1 : int'(t);
        endfunction

        // Move the corner so the cursor keeps its margin, then bound it to the map.
        function logic [7:0] trail(int cur, int corner, logic [DIM_W-1:0] m,
                                   logic [DIM_W-1:0] view, logic [MARGIN_W-1:0] margin);
            int mg, vw, far_edge, bound;
            mg = margin;
            vw = view;
            far_edge = vw - 1 - mg;
            bound = (span(m) > vw) ? span(m) - vw : 0;
            if (cur - corner < mg)
                corner = cur - mg;
            else if (cur - corner > far_edge)
                corner = cur - far_edge;
            return 8'(clamp(corner, 0, bound));
        endfunction

        function void recentre();
            cor_col = trail(int'(cur_col), int'(cor_col), map_w, view_w, margin_x);
            cor_row = trail(int'(cur_row), int'(cor_row), map_h, view_h, margin_y);
        endfunction

        function int dir_x();
            return int'(keys_down[3]) - int'(keys_down[2]);
        endfunction

        function int dir_y();
            return int'(keys_down[1]) - int'(keys_down[0]);
        endfunction

        // Advance the tracker by one accepted input word and owe its result.
        function void note_word(in_item_t w);
            logic      stepped;
            logic      fresh;
            out_item_t e;
            stepped = 1'b0;
            if (w.kind) begin
                cur_col = 8'(clamp(int'($signed(w.place_x)), 0, span(map_w) - 1));
                cur_row = 8'(clamp(int'($signed(w.place_y)), 0, span(map_h) - 1));
                prev_cur_col = cur_col;
                prev_cur_row = cur_row;
                recentre();
                prev_cor_col = cor_col;
                prev_cor_row = cor_row;
            end else begin
                fresh = |(w.held_keys & ~keys_down);
                keys_down = keys_down | w.held_keys;
                // any release reloads the delta from the keys still down
                if (w.released_keys != 0 || w.other_released) begin
                    keys_down = keys_down & ~w.released_keys;
                    fresh = 1'b1;
                    step_dx = 2'(dir_x());
                    step_dy = 2'(dir_y());
                end
                ticks = ticks + TICK_CNT_W'(w.elapsed_ticks);
                if (fresh) begin
                    ticks = '0;
                    stepped = 1'b1;
                    step_dx = 2'(clamp(dir_x() - int'(step_dx), -1, 1));
                    step_dy = 2'(clamp(dir_y() - int'(step_dy), -1, 1));
                    first_pending = 1'b1;
                end else if (first_pending && int'(ticks) >= threshold(first_thr)) begin
                    step_dx = 2'(dir_x());
                    step_dy = 2'(dir_y());
                    stepped = 1'b1;
                    first_pending = 1'b0;
                    ticks = TICK_CNT_W'(int'(ticks) % threshold(first_thr));
                end else if (!first_pending && int'(ticks) >= threshold(repeat_thr)) begin
                    step_dx = 2'(dir_x());
                    step_dy = 2'(dir_y());
                    stepped = 1'b1;
                    ticks = TICK_CNT_W'(int'(ticks) % threshold(repeat_thr));
                end
                if (stepped) begin
                    prev_cur_col = cur_col;
                    prev_cur_row = cur_row;
                    prev_cor_col = cor_col;
                    prev_cor_row = cor_row;
                    cur_col = 8'(clamp(int'(prev_cur_col) + int'(step_dx), 0, span(map_w) - 1));
                    cur_row = 8'(clamp(int'(prev_cur_row) + int'(step_dy), 0, span(map_h) - 1));
                    recentre();
                end
            end
            e.cursor_col = cur_col;
            e.cursor_row = cur_row;
            e.corner_col = cor_col;
            e.corner_row = cor_row;
            e.prev_cursor_col = prev_cur_col;
            e.prev_cursor_row = prev_cur_row;
            e.prev_corner_col = prev_cor_col;
            e.prev_corner_row = prev_cor_row;
            e.stepped = stepped;
            e.since_step = ticks;
            owed_views.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task compare(string field, int got, int want);
            if (got != want)
                report($sformatf("word %0d %s got %0d want %0d", words_seen, field, got, want));
        endtask

        task check_word(out_item_t got);
            out_item_t want;
            if (owed_views.size() == 0) begin
                report($sformatf("word %0d arrived with nothing owed", words_seen));
            end else begin
                want = owed_views.pop_front();
                compare("cursor_col", got.cursor_col, want.cursor_col);
                compare("cursor_row", got.cursor_row, want.cursor_row);
                compare("corner_col", got.corner_col, want.corner_col);
                compare("corner_row", got.corner_row, want.corner_row);
                compare("prev_cursor_col", got.prev_cursor_col, want.prev_cursor_col);
                compare("prev_cursor_row", got.prev_cursor_row, want.prev_cursor_row);
                compare("prev_corner_col", got.prev_corner_col, want.prev_corner_col);
                compare("prev_corner_row", got.prev_corner_row, want.prev_corner_row);
                compare("stepped", got.stepped, want.stepped);
                compare("since_step", got.since_step, want.since_step);
            end
            words_seen++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    cursor_tracker tracker = new();
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cur_repeat;
    logic [3:0]    user_held;

    key_repeat_cursor_scroll_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Check the word taken at this edge, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_word(m_data);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(in_item_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        tracker.note_word(w);
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.owed_views.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apply_setting(int mw, int mh, int vw, int vh, int mx, int my,
                                 int fr, int rp);
        logic [CFG_IDX_W-1:0]  order [8];
        logic [CFG_DATA_W-1:0] vals [8];
        order = '{CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_VIEW_WIDTH, CFG_VIEW_HEIGHT,
                  CFG_MARGIN_X, CFG_MARGIN_Y, CFG_FIRST_REPEAT, CFG_REPEAT};
        vals = '{16'(mw), 16'(mh), 16'(vw), 16'(vh), 16'(mx), 16'(my), 16'(fr), 16'(rp)};
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            tracker.set_reg(order[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        cur_repeat = rp;
    endtask

    function automatic in_item_t frame_word(logic [3:0] held, logic [3:0] rel,
                                            logic other, logic [15:0] el);
        in_item_t w;
        w = '0;
        w.held_keys = held;
        w.released_keys = rel;
        w.other_released = other;
        w.elapsed_ticks = el;
        return w;
    endfunction

    function automatic in_item_t place_word(int x, int y);
        in_item_t w;
        w = '0;
        w.kind = 1'b1;
        w.place_x = 16'(x);
        w.place_y = 16'(y);
        return w;
    endfunction

    // Mostly steady holds with occasional presses and releases; some placements and noise words.
    function automatic in_item_t random_word();
        in_item_t   w;
        int         r;
        int         lim;
        logic [3:0] press, drop;
        w = '0;
        w.place_x = 16'($urandom);
        w.place_y = 16'($urandom);
        r = $urandom_range(99);
        if (r < 8) begin
            w.kind = 1'b1;
            if ($urandom_range(1) == 1) begin
                w.place_x = 16'($urandom_range(0, 300));
                w.place_y = 16'($urandom_range(0, 300));
            end
        end else if (r < 15) begin
            w.held_keys = 4'($urandom);
            w.released_keys = 4'($urandom);
            w.other_released = 1'($urandom);
            w.elapsed_ticks = 16'($urandom);
            user_held = (user_held | w.held_keys) & ~w.released_keys;
        end else begin
            press = ($urandom_range(9) == 0) ? 4'($urandom) & ~user_held : 4'h0;
            drop  = ($urandom_range(11) == 0) ? 4'($urandom) & user_held : 4'h0;
            user_held = user_held | press;
            w.held_keys = user_held;
            w.released_keys = drop;
            user_held = user_held & ~drop;
            w.other_released = ($urandom_range(39) == 0);
            lim = ((cur_repeat < 1 ? 1 : cur_repeat) + 1) * 2 / 3;
            if (lim > 65535)
                lim = 65535;
            case ($urandom_range(9))
                0: w.elapsed_ticks = 16'($urandom);
                1: w.elapsed_ticks = '0;
                default: w.elapsed_ticks = 16'($urandom_range(0, lim));
            endcase
        end
        return w;
    endfunction

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) begin
            send_word(random_word());
            if ($urandom_range(99) == 0)
                drain();
        end
        drain();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_repeat = 80;
        user_held = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words under the reset settings
        send_word(place_word(-32768, 32767));
        send_word(place_word(32767, -1));
        send_word(place_word(128, 100));
        send_word(frame_word(4'h8, 4'h0, 1'b0, 16'd0));
        send_word(frame_word(4'h8, 4'h0, 1'b0, 16'd299));
        send_word(frame_word(4'h8, 4'h0, 1'b0, 16'd1));
        send_word(frame_word(4'h8, 4'h0, 1'b0, 16'd160));
        // newly pressed down steps only down
        send_word(frame_word(4'hA, 4'h0, 1'b0, 16'd5));
        // held and released together: hold first, then release
        send_word(frame_word(4'hA, 4'h8, 1'b0, 16'd7));
        send_word(frame_word(4'h0, 4'h0, 1'b1, 16'd3));
        // key already down gives no fresh press
        send_word(frame_word(4'h2, 4'h0, 1'b0, 16'd40));
        send_word(frame_word(4'h4, 4'h0, 1'b0, 16'd0));
        send_word(frame_word(4'h0, 4'h0, 1'b0, 16'hFFFF));
        send_word(frame_word(4'h0, 4'h0, 1'b0, 16'hFFFF));
        send_word(frame_word(4'hF, 4'h0, 1'b0, 16'd100));
        send_word(frame_word(4'h0, 4'hF, 1'b1, 16'hFFFF));
        send_word(frame_word(4'h0, 4'h0, 1'b0, 16'd400));
        send_word(place_word(0, 0));
        send_word(frame_word(4'h1, 4'h0, 1'b0, 16'd0));
        send_word(frame_word(4'h5, 4'h0, 1'b0, 16'hFFFF));
        send_word(place_word(255, 255));
        send_word(frame_word(4'hA, 4'h0, 1'b0, 16'd0));
        drain();

        apply_setting(40, 30, 16, 12, 2, 2, 20, 8);
        run_phase(150, 0, 0);
        // zero thresholds, map size zero and oversized, view larger than map
        apply_setting(0, 511, 256, 1, 127, 0, 0, 0);
        send_word(place_word(300, 300));
        run_phase(120, 75, 0);
        apply_setting(256, 256, 1, 256, 0, 127, 65535, 65535);
        send_word(place_word(-5, 200));
        run_phase(120, 0, 75);
        apply_setting(20, 9, 7, 5, 3, 1, 3, 1);
        run_phase(150, 12, 12);
        apply_setting($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(1, 256),
                      $urandom_range(1, 256), $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(1, 600), $urandom_range(1, 200));
        case ($urandom_range(3))
            0: run_phase(110, 0, 0);
            1: run_phase(110, 75, 0);
            2: run_phase(110, 0, 75);
            default: run_phase(110, 12, 12);
        endcase

        repeat (40) @(posedge aclk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
